// ===== hdl/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants for the mecanum wheel odometry unit.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int unsigned VEL_W    = 32;
    localparam int unsigned PER_W    = 24;
    localparam int unsigned GEOM_W   = 24;
    localparam int unsigned INVR_W   = 28;
    localparam int unsigned ANGLE_W  = 32;
    localparam int unsigned KW_W     = 57;   // |K*wz| < 2^56
    localparam int unsigned NUM_W    = 58;   // numerator, signed Q.33
    localparam int unsigned NWHEEL   = 4;

    // round(2^32/pi): radians to binary radians in Q.32
    localparam logic [30:0] BRAD_PER_RAD = 31'd1367130551;

    // register map, word index
    localparam logic [2:0] REG_TRACK_SPAN  = 3'd0;
    localparam logic [2:0] REG_AXLE_SPAN   = 3'd1;
    localparam logic [2:0] REG_INV_RADIUS  = 3'd2;
    localparam logic [2:0] REG_INIT_FL     = 3'd3;
    localparam logic [2:0] REG_INIT_FR     = 3'd4;
    localparam logic [2:0] REG_INIT_RL     = 3'd5;
    localparam logic [2:0] REG_INIT_RR     = 3'd6;

    localparam logic [GEOM_W-1:0] TREAD_RESET = 24'd65536;
    localparam logic [GEOM_W-1:0] BASE_RESET  = 24'd65536;
    localparam logic [INVR_W-1:0] INVR_RESET  = 28'd655360;

    // command word after the yaw term has been formed
    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [KW_W-1:0]  kw;
        logic [PER_W-1:0]        period;
    } cmd_entry_t;

    // initial angle write, loads one wheel's angle
    typedef struct packed {
        logic                    valid;
        logic [1:0]              wheel;
        logic [ANGLE_W-1:0]      value;
    } angle_load_t;

endpackage

// ===== hdl/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Input register for command words; forms the yaw term K*wz and feeds the
// command queue.
// ----------------------------------------------------------------------------
module mwo_front
    import mwo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VEL_W-1:0]  in_vx,
    input  logic signed [VEL_W-1:0]  in_vy,
    input  logic signed [VEL_W-1:0]  in_wz,
    input  logic [PER_W-1:0]         in_period,
    input  logic [GEOM_W-1:0]        track_span,
    input  logic [GEOM_W-1:0]        axle_span,
    output logic                     push,
    output cmd_entry_t               push_data,
    input  logic                     queue_full
);

    logic                    f_valid_reg;
    logic                    f_valid_next;
    logic signed [VEL_W-1:0] f_vx_reg;
    logic signed [VEL_W-1:0] f_vy_reg;
    logic signed [VEL_W-1:0] f_wz_reg;
    logic [PER_W-1:0]        f_per_reg;

    logic [GEOM_W:0]         k_sum;
    logic signed [GEOM_W+1:0] k_sgn;
    logic signed [KW_W-1:0]  kw_full;
    logic                    take;

    // K = tread + base is k in Q.17; 26 x 32 signed product
    assign k_sum   = {1'b0, track_span} + {1'b0, axle_span};
    assign k_sgn   = $signed({1'b0, k_sum});
    assign kw_full = k_sgn * f_wz_reg;

    assign push     = f_valid_reg && !queue_full;
    assign in_ready = !f_valid_reg || !queue_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        push_data.vx     = f_vx_reg;
        push_data.vy     = f_vy_reg;
        push_data.kw     = kw_full;
        push_data.period = f_per_reg;
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (take)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_vx_reg  <= in_vx;
            f_vy_reg  <= in_vy;
            f_wz_reg  <= in_wz;
            f_per_reg <= in_period;
        end
    end

endmodule

// ===== hdl/mwo_queue.sv =====
// ----------------------------------------------------------------------------
// mwo_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mwo_queue
    import mwo_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output cmd_entry_t pop_data,
    output logic       empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Per-wheel pipeline: numerator, scaling by 1/r with saturation, angle step
// and angle integration. One wheel enters per cycle; the whole pipe holds
// while a finished word waits on a full output register.
// ----------------------------------------------------------------------------
module mwo_back
    import mwo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     queue_empty,
    input  cmd_entry_t               queue_data,
    output logic                     pop,
    input  logic [INVR_W-1:0]        inv_radius,
    input  angle_load_t              angle_load,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ANGLE_W-1:0]       out_rate [NWHEEL],
    output logic [ANGLE_W-1:0]       out_angle [NWHEEL]
);

    // issue
    logic              busy_reg, busy_next;
    logic [1:0]        widx_reg, widx_next;
    cmd_entry_t        cmd_reg;
    logic              adv;
    logic              issue_free;

    // stage 1: numerator
    logic                    s1_valid_reg;
    logic [1:0]              s1_idx_reg;
    logic signed [NUM_W-1:0] s1_sum_reg;
    logic [PER_W-1:0]        s1_per_reg;
    // stage 2: magnitude split
    logic                    s2_valid_reg;
    logic [1:0]              s2_idx_reg;
    logic                    s2_neg_reg;
    logic [27:0]             s2_hi_reg;
    logic [28:0]             s2_lo_reg;
    logic [PER_W-1:0]        s2_per_reg;
    // stage 3: partial products with 1/r
    logic                    s3_valid_reg;
    logic [1:0]              s3_idx_reg;
    logic                    s3_neg_reg;
    logic [55:0]             s3_a_reg;
    logic [56:0]             s3_b_reg;
    logic [PER_W-1:0]        s3_per_reg;
    // stage 4: saturated rate
    logic                    s4_valid_reg;
    logic [1:0]              s4_idx_reg;
    logic [31:0]             s4_rate_reg;
    logic [PER_W-1:0]        s4_per_reg;
    // stage 5: rate magnitude
    logic                    s5_valid_reg;
    logic [1:0]              s5_idx_reg;
    logic [31:0]             s5_rate_reg;
    logic [31:0]             s5_rm_reg;
    logic [PER_W-1:0]        s5_per_reg;
    // stage 6: rate times period
    logic                    s6_valid_reg;
    logic [1:0]              s6_idx_reg;
    logic [31:0]             s6_rate_reg;
    logic [55:0]             s6_m_reg;
    // stage 7: partial products with brad scale
    logic                    s7_valid_reg;
    logic [1:0]              s7_idx_reg;
    logic [31:0]             s7_rate_reg;
    logic [54:0]             s7_a_reg;
    logic [62:0]             s7_b_reg;

    logic [ANGLE_W-1:0]      angle_reg [NWHEEL];
    logic [ANGLE_W-1:0]      col_rate_reg [NWHEEL-1];
    logic [ANGLE_W-1:0]      col_angle_reg [NWHEEL-1];
    logic [ANGLE_W-1:0]      out_rate_reg [NWHEEL];
    logic [ANGLE_W-1:0]      out_angle_reg [NWHEEL];
    logic                    out_valid_reg, out_valid_next;

    logic signed [NUM_W-1:0] vx_ext, vy_ext, kw_ext, vy_term, kw_term, sum;
    logic                    vy_neg, kw_neg;
    logic [NUM_W-1:0]        mag;
    logic [57:0]             q_low;
    logic [52:0]             q;
    logic [31:0]             rate_sat;
    logic [55:0]             a_full;
    logic [56:0]             b_full;
    logic [55:0]             m_full;
    logic [54:0]             a2_full;
    logic [62:0]             b2_full;
    logic [63:0]             d_low;
    logic [31:0]             d32;
    logic [31:0]             step;
    logic [ANGLE_W-1:0]      angle_new;
    logic                    retire;
    logic                    retire_last;

    // ---- control ----
    assign retire      = s7_valid_reg && adv;
    assign retire_last = retire && (s7_idx_reg == 2'd3);
    assign adv         = !(s7_valid_reg && (s7_idx_reg == 2'd3) && out_valid_reg
                           && !out_ready);
    assign issue_free  = !busy_reg || (widx_reg == 2'd3);
    assign pop         = adv && issue_free && !queue_empty;

    always_comb
    begin
        busy_next = busy_reg;
        widx_next = widx_reg;
        if (adv)
        begin
            if (pop)
            begin
                busy_next = 1'b1;
                widx_next = 2'd0;
            end
            else if (busy_reg)
            begin
                busy_next = (widx_reg != 2'd3);
                widx_next = widx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (retire_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            widx_reg      <= 2'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s1_valid_reg <= busy_reg;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                s6_valid_reg <= s5_valid_reg;
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    // ---- datapath ----
    // wheel sign pattern: w0 = vx-vy-kw, w1 = vx+vy+kw, w2 = vx+vy-kw, w3 = vx-vy+kw
    assign vy_neg  = (widx_reg == 2'd0) || (widx_reg == 2'd3);
    assign kw_neg  = (widx_reg == 2'd0) || (widx_reg == 2'd2);
    assign vx_ext  = $signed({{(NUM_W-VEL_W-17){cmd_reg.vx[VEL_W-1]}}, cmd_reg.vx, 17'd0});
    assign vy_ext  = $signed({{(NUM_W-VEL_W-17){cmd_reg.vy[VEL_W-1]}}, cmd_reg.vy, 17'd0});
    assign kw_ext  = $signed({cmd_reg.kw[KW_W-1], cmd_reg.kw});
    assign vy_term = vy_neg ? -vy_ext : vy_ext;
    assign kw_term = kw_neg ? -kw_ext : kw_ext;
    assign sum     = vx_ext + vy_term + kw_term;

    assign mag    = s1_sum_reg[NUM_W-1] ? NUM_W'(-s1_sum_reg) : NUM_W'(s1_sum_reg);
    assign a_full = 56'(s2_hi_reg) * 56'(inv_radius);
    assign b_full = 57'(s2_lo_reg) * 57'(inv_radius);

    // round half away from zero at bit 33, then saturate
    assign q_low = {25'd0, s3_a_reg[3:0], 29'd0} + {1'b0, s3_b_reg} + 58'h1_0000_0000;
    assign q     = {1'b0, s3_a_reg[55:4]} + {28'd0, q_low[57:33]};

    always_comb
    begin
        if (s3_neg_reg)
        begin
            rate_sat = (|q[52:31]) ? 32'h8000_0000 : 32'(-q[31:0]);
        end
        else
        begin
            rate_sat = (|q[52:31]) ? 32'h7FFF_FFFF : q[31:0];
        end
    end

    assign m_full  = 56'(s5_rm_reg) * 56'(s5_per_reg);
    assign a2_full = 55'(s6_m_reg[55:32]) * 55'(BRAD_PER_RAD);
    assign b2_full = 63'(s6_m_reg[31:0]) * 63'(BRAD_PER_RAD);

    // angle step rounded at bit 41, only the low 32 bits matter
    assign d_low     = {23'd0, s7_a_reg[8:0], 32'd0} + {1'b0, s7_b_reg} + 64'h100_0000_0000;
    assign d32       = s7_a_reg[40:9] + {9'd0, d_low[63:41]};
    assign step      = s7_rate_reg[31] ? 32'(-d32) : d32;
    assign angle_new = angle_reg[s7_idx_reg] + step;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= queue_data;
        end
        if (adv)
        begin
            s1_idx_reg  <= widx_reg;
            s1_sum_reg  <= sum;
            s1_per_reg  <= cmd_reg.period;

            s2_idx_reg  <= s1_idx_reg;
            s2_neg_reg  <= s1_sum_reg[NUM_W-1];
            s2_hi_reg   <= mag[56:29];
            s2_lo_reg   <= mag[28:0];
            s2_per_reg  <= s1_per_reg;

            s3_idx_reg  <= s2_idx_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_a_reg    <= a_full;
            s3_b_reg    <= b_full;
            s3_per_reg  <= s2_per_reg;

            s4_idx_reg  <= s3_idx_reg;
            s4_rate_reg <= rate_sat;
            s4_per_reg  <= s3_per_reg;

            s5_idx_reg  <= s4_idx_reg;
            s5_rate_reg <= s4_rate_reg;
            s5_rm_reg   <= s4_rate_reg[31] ? 32'(-s4_rate_reg) : s4_rate_reg;
            s5_per_reg  <= s4_per_reg;

            s6_idx_reg  <= s5_idx_reg;
            s6_rate_reg <= s5_rate_reg;
            s6_m_reg    <= m_full;

            s7_idx_reg  <= s6_idx_reg;
            s7_rate_reg <= s6_rate_reg;
            s7_a_reg    <= a2_full;
            s7_b_reg    <= b2_full;
        end
        if (retire && !retire_last)
        begin
            col_rate_reg[s7_idx_reg[1:0]]  <= s7_rate_reg;
            col_angle_reg[s7_idx_reg[1:0]] <= angle_new;
        end
        if (retire_last)
        begin
            for (int i = 0; i < NWHEEL - 1; i++)
            begin
                out_rate_reg[i]  <= col_rate_reg[i];
                out_angle_reg[i] <= col_angle_reg[i];
            end
            out_rate_reg[NWHEEL-1]  <= s7_rate_reg;
            out_angle_reg[NWHEEL-1] <= angle_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NWHEEL; i++)
            begin
                angle_reg[i] <= '0;
            end
        end
        else if (angle_load.valid)
        begin
            angle_reg[angle_load.wheel] <= angle_load.value;
        end
        else if (retire)
        begin
            angle_reg[s7_idx_reg] <= angle_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rate  = out_rate_reg;
    assign out_angle = out_angle_reg;

    // wheels of one command travel back to back through the pipe
    a_wheel_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && (s1_idx_reg != 2'd0))
            |-> (s1_idx_reg == s2_idx_reg + 2'd1))
        else $error("wheel tokens out of order");

    a_hold_token: assert property (@(posedge clk) disable iff (!rst_n)
        (s7_valid_reg && !adv) |=> (s7_valid_reg && $stable(s7_idx_reg)))
        else $error("stalled wheel token lost");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        retire_last |=> out_valid_reg)
        else $error("finished word not presented");

endmodule

// ===== hdl/mecanum_wheel_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry_unit
// Mecanum four-wheel inverse kinematics with wheel angle integration.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one velocity command word (vx, vy, yaw rate, period).
//   m_axis returns one word per command: four saturated wheel rates and the
//   four wheel angles after this command's update (binary radians).
//   The APB port holds geometry and 1/r; writing an initial-angle register
//   also loads that wheel's running angle. Write registers only while idle.
// Timing:
//   A command passes the front register, queue, command register, back-end
//   pipeline and output register before m_axis_tvalid. The back end issues
//   the four wheels one per cycle, unless held, through a single shared
//   multiply pipeline, and commands overlap in it. A command queue lets the
//   front end keep accepting while the back end or the output is held.
// Reset:
//   rst_n clears the queue, the pipeline and all wheel angles; registers
//   return to 1 m tread, 1 m base and 10 1/m inverse radius.
// Stall:
//   If m_axis_tready is low, the finished word holds, the pipeline freezes
//   when the next word is complete, then the queue fills and s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
module mecanum_wheel_odometry_unit
    import mwo_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    // vel_forward[31:0], vel_sideways[63:32], yaw_rate[95:64], step_period[119:96]
    input  logic [119:0]  s_axis_tdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // rate_0..rate_3 at [31:0]..[127:96], angle_0..angle_3 at [159:128]..[255:224]
    output logic [255:0]  m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [GEOM_W-1:0]  tread_reg;
    logic [GEOM_W-1:0]  base_reg;
    logic [INVR_W-1:0]  invr_reg;
    logic [ANGLE_W-1:0] init_reg [NWHEEL];
    logic               wr_en;
    logic [2:0]         reg_idx;
    angle_load_t        angle_load;

    logic               push;
    cmd_entry_t         push_data;
    logic               queue_full;
    logic               pop;
    cmd_entry_t         pop_data;
    logic               queue_empty;
    logic [ANGLE_W-1:0] out_rate [NWHEEL];
    logic [ANGLE_W-1:0] out_angle [NWHEEL];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        angle_load.valid = wr_en && (reg_idx >= REG_INIT_FL) && (reg_idx <= REG_INIT_RR);
        angle_load.wheel = 2'(reg_idx - REG_INIT_FL);
        angle_load.value = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tread_reg <= TREAD_RESET;
            base_reg  <= BASE_RESET;
            invr_reg  <= INVR_RESET;
            for (int i = 0; i < NWHEEL; i++)
            begin
                init_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TRACK_SPAN:  tread_reg   <= pwdata[GEOM_W-1:0];
                REG_AXLE_SPAN:   base_reg    <= pwdata[GEOM_W-1:0];
                REG_INV_RADIUS:  invr_reg    <= pwdata[INVR_W-1:0];
                REG_INIT_FL:     init_reg[0] <= pwdata;
                REG_INIT_FR:     init_reg[1] <= pwdata;
                REG_INIT_RL:     init_reg[2] <= pwdata;
                REG_INIT_RR:     init_reg[3] <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRACK_SPAN:  prdata = {8'd0, tread_reg};
            REG_AXLE_SPAN:   prdata = {8'd0, base_reg};
            REG_INV_RADIUS:  prdata = {4'd0, invr_reg};
            REG_INIT_FL:     prdata = init_reg[0];
            REG_INIT_FR:     prdata = init_reg[1];
            REG_INIT_RL:     prdata = init_reg[2];
            REG_INIT_RR:     prdata = init_reg[3];
            default:         prdata = 32'd0;
        endcase
    end

    mwo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_vx       ($signed(s_axis_tdata[31:0])),
        .in_vy       ($signed(s_axis_tdata[63:32])),
        .in_wz       ($signed(s_axis_tdata[95:64])),
        .in_period   (s_axis_tdata[119:96]),
        .track_span  (tread_reg),
        .axle_span   (base_reg),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (queue_full)
    );

    mwo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    mwo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .inv_radius  (invr_reg),
        .angle_load  (angle_load),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_rate    (out_rate),
        .out_angle   (out_angle)
    );

    assign m_axis_tdata = {out_angle[3], out_angle[2], out_angle[1], out_angle[0],
                           out_rate[3], out_rate[2], out_rate[1], out_rate[0]};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mecanum wheel odometry unit. Velocity commands
// go in over the input stream under several geometry and angle settings.
// Every output word is compared field by field with a bit-accurate model of
// the wheel kinematics and the binary-radian angle integration.
// ----------------------------------------------------------------------------
module tb;
    import mwo_pkg::*;

    localparam logic [2:0]  REG_UNMAPPED = 3'd7;
    localparam int          MAX_CYCLES   = 200000;
    localparam int          DRAIN_CYCLES = 24;
    localparam logic [31:0] VEL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN      = 32'h8000_0000;
    localparam logic [23:0] PER_MAX      = 24'hFF_FFFF;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [VEL_W-1:0] wz;
        logic [VEL_W-1:0] vy;
        logic [VEL_W-1:0] vx;
    } vel_cmd_t;

    typedef struct packed {
        logic [NWHEEL-1:0][ANGLE_W-1:0] angle;
        logic [NWHEEL-1:0][VEL_W-1:0]   rate;
    } wheel_word_t;

    class odometry_scoreboard;
        logic [GEOM_W-1:0]  tread;
        logic [GEOM_W-1:0]  base;
        logic [INVR_W-1:0]  inv_r;
        logic [ANGLE_W-1:0] angle [NWHEEL];
        wheel_word_t        expected_words [$];
        int                 errors;

        function new();
            tread = TREAD_RESET;
            base  = BASE_RESET;
            inv_r = INVR_RESET;
            foreach (angle[i]) angle[i] = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_TRACK_SPAN:  tread = val[GEOM_W-1:0];
                REG_AXLE_SPAN:   base  = val[GEOM_W-1:0];
                REG_INV_RADIUS:  inv_r = val[INVR_W-1:0];
                REG_INIT_FL, REG_INIT_FR, REG_INIT_RL, REG_INIT_RR:
                    angle[idx - REG_INIT_FL] = val;
                default: ;
            endcase
        endfunction

        // Q.33 numerator times 1/r, nearest with ties away from zero, saturated
        function logic [31:0] rate_from_numerator(logic signed [NUM_W-1:0] num);
            logic [NUM_W-1:0] mag;
            logic [95:0]      q;
            mag = num[NUM_W-1] ? -num : num;
            q = ({38'd0, mag} * {68'd0, inv_r} + (96'd1 << 32)) >> 33;
            if (num[NUM_W-1])
                return (q >= 96'h8000_0000) ? 32'h8000_0000 : -q[31:0];
            return (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        endfunction

        // rate * period in Q.40 rad, scaled to binary radians
        function logic [31:0] angle_increment(logic [31:0] rate, logic [PER_W-1:0] per);
            logic [31:0] rm;
            logic [95:0] m;
            logic [95:0] d;
            rm = rate[31] ? -rate : rate;
            m  = {64'd0, rm} * {72'd0, per};
            d  = (m * {65'd0, BRAD_PER_RAD} + (96'd1 << 40)) >> 41;
            return rate[31] ? -d[31:0] : d[31:0];
        endfunction

        function void predict_odometry(vel_cmd_t cmd);
            logic signed [NUM_W-1:0] vx_n, vy_n, kw;
            logic signed [NUM_W-1:0] num [NWHEEL];
            wheel_word_t             w;
            vx_n = {{9{cmd.vx[31]}}, cmd.vx, 17'd0};
            vy_n = {{9{cmd.vy[31]}}, cmd.vy, 17'd0};
            // tread + base is k in Q.17
            kw = $signed({33'd0, {1'b0, tread} + {1'b0, base}})
                 * $signed({{26{cmd.wz[31]}}, cmd.wz});
            num[0] = vx_n - vy_n - kw;
            num[1] = vx_n + vy_n + kw;
            num[2] = vx_n + vy_n - kw;
            num[3] = vx_n - vy_n + kw;
            for (int i = 0; i < NWHEEL; i++) begin
                w.rate[i]  = rate_from_numerator(num[i]);
                angle[i]   = angle[i] + angle_increment(w.rate[i], cmd.period);
                w.angle[i] = angle[i];
            end
            expected_words.push_back(w);
        endfunction

        function void check_odometry(wheel_word_t got);
            wheel_word_t want;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_words.pop_front();
            for (int i = 0; i < NWHEEL; i++) begin
                if (got.rate[i] !== want.rate[i]) begin
                    errors++;
                    $display("%0t: rate_%0d expected %h actual %h",
                             $time, i, want.rate[i], got.rate[i]);
                end
                if (got.angle[i] !== want.angle[i]) begin
                    errors++;
                    $display("%0t: angle_%0d expected %h actual %h",
                             $time, i, want.angle[i], got.angle[i]);
                end
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [119:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    odometry_scoreboard sb;
    bit                 no_gaps = 1'b0;
    int                 cycle_count = 0;

    mecanum_wheel_odometry_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: values read here are the ones present at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_odometry(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.predict_odometry(s_axis_tdata);
            if (psel && penable && pwrite && pready)
                sb.write_reg(paddr[4:2], pwdata);
        end
    end

    // Output side: random stall before each word
    initial
    begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    task automatic send_cmd(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] wz, input logic [23:0] per);
        vel_cmd_t cmd;
        int       gap;
        cmd.vx     = vx;
        cmd.vy     = vy;
        cmd.wz     = wz;
        cmd.period = per;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drain everything in flight before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [31:0] tread, input logic [31:0] base,
                                input logic [31:0] inv_r);
        apb_write(REG_TRACK_SPAN, tread);
        apb_write(REG_AXLE_SPAN, base);
        apb_write(REG_INV_RADIUS, inv_r);
    endtask

    task automatic set_angles(input logic [31:0] a0, input logic [31:0] a1,
                              input logic [31:0] a2, input logic [31:0] a3);
        apb_write(REG_INIT_FL, a0);
        apb_write(REG_INIT_FR, a1);
        apb_write(REG_INIT_RL, a2);
        apb_write(REG_INIT_RR, a3);
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return 32'($urandom_range(0, 2097152)) - 32'd1048576;
            8:             return VEL_MAX;
            default:       return VEL_MIN;
        endcase
    endfunction

    function automatic logic [23:0] rand_period();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 24'($urandom);
            6, 7:             return 24'($urandom_range(0, 65535));
            8:                return '0;
            default:          return PER_MAX;
        endcase
    endfunction

    // full-width values also exercise the masked upper bits
    function automatic logic [31:0] rand_geom();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return $urandom_range(1, 24'h4_0000);
            6:       return 32'h00FF_FFFF;
            7:       return 32'd1;
            8:       return 32'd0;
            default: return $urandom_range(24'h0_8000, 24'h3_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_inv();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return $urandom_range(65536, 2000000);
            6:       return 32'h0FFF_FFFF;
            7:       return 32'd1;
            8:       return 32'd0;
            default: return INVR_RESET;
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 4))
            0, 1:    return $urandom;
            2:       return VEL_MAX - $urandom_range(0, 4096);
            3:       return VEL_MIN + $urandom_range(0, 4096);
            default: return '0;
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: field extremes, saturation, zero period
        send_cmd(32'd0, 32'd0, 32'd0, 24'd0);
        send_cmd(VEL_MAX, 32'd0, 32'd0, PER_MAX);
        send_cmd(VEL_MIN, 32'd0, 32'd0, PER_MAX);
        send_cmd(32'd0, VEL_MAX, 32'd0, PER_MAX);
        send_cmd(32'd0, VEL_MIN, 32'd0, PER_MAX);
        send_cmd(32'd0, 32'd0, VEL_MAX, PER_MAX);
        send_cmd(32'd0, 32'd0, VEL_MIN, PER_MAX);
        send_cmd(VEL_MAX, VEL_MAX, VEL_MAX, PER_MAX);
        send_cmd(VEL_MIN, VEL_MIN, VEL_MIN, PER_MAX);
        send_cmd(VEL_MAX, VEL_MIN, VEL_MAX, 24'd1);
        send_cmd(32'd65536, 32'd32768, -32'sd65536, 24'd0);
        send_cmd(32'd65536, -32'sd1, 32'd1, 24'd16777);

        // zero tread and base: k vanishes
        wait_idle();
        set_geometry(32'd0, 32'd0, INVR_RESET);
        send_cmd(VEL_MAX, VEL_MIN, VEL_MAX, PER_MAX);
        send_cmd(32'd12345, -32'sd54321, VEL_MIN, 24'h80_0000);

        // zero inverse radius: rates zero, angles hold
        wait_idle();
        apb_write(REG_INV_RADIUS, 32'd0);
        send_cmd(VEL_MAX, VEL_MAX, VEL_MAX, PER_MAX);
        send_cmd(VEL_MIN, 32'd100, VEL_MIN, PER_MAX);

        // largest geometry and inverse radius: heavy saturation
        wait_idle();
        set_geometry(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0FFF_FFFF);
        send_cmd(32'd1, -32'sd1, 32'd1, PER_MAX);
        send_cmd(VEL_MIN, VEL_MAX, VEL_MIN, PER_MAX);
        send_cmd(32'd70000, 32'd0, -32'sd3, 24'h00_1000);

        // angles next to the wrap point; write to an unmapped index is ignored
        wait_idle();
        set_geometry(32'h0001_0000, 32'h0001_8000, INVR_RESET);
        set_angles(32'h7FFF_FF00, 32'h8000_0100, 32'h7FFF_FFFF, 32'h8000_0000);
        apb_write(REG_UNMAPPED, $urandom);
        send_cmd(32'h0100_0000, 32'd0, 32'd0, PER_MAX);
        send_cmd(VEL_MIN, 32'd0, 32'd0, PER_MAX);
        send_cmd(32'd0, VEL_MAX, VEL_MAX, PER_MAX);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            set_geometry(rand_geom(), rand_geom(), rand_inv());
            if ($urandom_range(0, 1))
                set_angles(rand_angle(), rand_angle(), rand_angle(), rand_angle());
            if ($urandom_range(0, 2) == 0)
                apb_write(REG_UNMAPPED, $urandom);
            for (int n = 0; n < 90; n++)
            begin
                if (n % 30 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                send_cmd(rand_vel(), rand_vel(), rand_vel(), rand_period());
            end
        end

        no_gaps = 1'b0;
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
